/* hdl/pawm_pkg.sv */
`timescale 1ns / 1ps

package pawm_pkg;

  // fixed field widths of the two channels
  localparam int CHAN_BITS   = 3;
  localparam int LEVEL_BITS  = 16;
  localparam int WCOUNT_BITS = 13;

  // sum of squares saturates at 2^43 - 1
  localparam int SUM_BITS = 43;
  localparam logic [SUM_BITS-1:0] SUM_LIMIT = {SUM_BITS{1'b1}};

  // widest window count carried in a report (WINDOW_MAX up to 131071)
  localparam int REP_CNT_BITS = 17;

  // root of a SUM_BITS value, one bit pair per step
  localparam int ROOT_BITS = (SUM_BITS + 1) / 2;
  localparam int RAD_BITS  = 2 * ROOT_BITS;

  // report queue between front and back
  localparam int QDEPTH = 4;

  // parameter defaults
  localparam int CHANNELS_DEF    = 8;
  localparam int WINDOW_MAX_DEF  = 4096;
  localparam int SAMPLE_BITS_DEF = 16;

  typedef struct packed {
    logic [CHAN_BITS-1:0]         chan;
    logic signed [LEVEL_BITS-1:0] sample_value;
    logic                         first_of_window;
    logic                         last_of_window;
  } pawm_in_t;

  typedef struct packed {
    logic [CHAN_BITS-1:0]   out_chan;
    logic [LEVEL_BITS-1:0]  peak_level;
    logic [LEVEL_BITS-1:0]  rms_level;
    logic [WCOUNT_BITS-1:0] window_count;
    logic                   window_overflow;
  } pawm_out_t;

  // closed window handed from front to back
  typedef struct packed {
    logic [CHAN_BITS-1:0]    chan;
    logic [LEVEL_BITS-1:0]   peak;
    logic [SUM_BITS-1:0]     sum;
    logic [REP_CNT_BITS-1:0] count;
    logic                    overflow;
  } pawm_rep_t;

  // queue status seen by the front
  typedef struct packed {
    logic almost_full;
    logic empty;
  } pawm_qstat_t;

endpackage

/* hdl/pawm_front.sv */
`timescale 1ns / 1ps

module pawm_front #(
  parameter int CHANNELS    = pawm_pkg::CHANNELS_DEF,
  parameter int WINDOW_MAX  = pawm_pkg::WINDOW_MAX_DEF,
  parameter int SAMPLE_BITS = pawm_pkg::SAMPLE_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                sample_valid,
  output logic                sample_stall,
  input  pawm_pkg::pawm_in_t  sample,
  input  pawm_pkg::pawm_qstat_t qstat,
  output logic                push,
  output pawm_pkg::pawm_rep_t push_data
);
  import pawm_pkg::*;

  localparam int SQ_W   = 2 * SAMPLE_BITS;
  localparam int SUMX_W = ((SQ_W > SUM_BITS) ? SQ_W : SUM_BITS) + 1;
  localparam int CNT_W  = $clog2(WINDOW_MAX + 1);

  logic                        accept;
  logic [SAMPLE_BITS+15:0]     sample_ext;
  logic [SAMPLE_BITS-1:0]      raw;
  logic [SAMPLE_BITS-1:0]      mag_in;

  // stage 1: magnitude
  logic                        s1_valid;
  logic [CHAN_BITS-1:0]        s1_chan;
  logic [SAMPLE_BITS-1:0]      s1_mag;
  logic                        s1_first;
  logic                        s1_last;

  // stage 2: square, then accumulate
  logic                        s2_valid;
  logic [CHAN_BITS-1:0]        s2_chan;
  logic [SAMPLE_BITS-1:0]      s2_mag;
  logic [SQ_W-1:0]             s2_sq;
  logic                        s2_first;
  logic                        s2_last;

  logic [SAMPLE_BITS-1:0]      peak_store   [CHANNELS];
  logic [SUM_BITS-1:0]         sum_store    [CHANNELS];
  logic [CNT_W-1:0]            count_store  [CHANNELS];
  logic                        ovf_store    [CHANNELS];

  logic [SAMPLE_BITS-1:0]      rd_peak;
  logic [SUM_BITS-1:0]         rd_sum;
  logic [CNT_W-1:0]            rd_count;
  logic                        rd_ovf;

  logic [SAMPLE_BITS-1:0]      peak_next;
  logic [SUM_BITS-1:0]         sum_next;
  logic [CNT_W-1:0]            count_next;
  logic                        ovf_next;
  logic [SUMX_W-1:0]           sum_wide;

  assign sample_stall = qstat.almost_full;
  assign accept       = sample_valid && !sample_stall;

  // low SAMPLE_BITS bits of the zero-extended sample are the signed sample
  assign sample_ext = {{SAMPLE_BITS{1'b0}}, sample.sample_value};
  assign raw        = sample_ext[SAMPLE_BITS-1:0];
  assign mag_in     = raw[SAMPLE_BITS-1] ? (~raw + 1'b1) : raw;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      s1_valid <= accept && (32'(sample.chan) < CHANNELS);
      s2_valid <= s1_valid;
    end
    s1_chan  <= sample.chan;
    s1_mag   <= mag_in;
    s1_first <= sample.first_of_window;
    s1_last  <= sample.last_of_window;
    s2_chan  <= s1_chan;
    s2_mag   <= s1_mag;
    s2_sq    <= SQ_W'(s1_mag) * SQ_W'(s1_mag);
    s2_first <= s1_first;
    s2_last  <= s1_last;
  end

  // channel read, base is zero on a first mark
  always_comb begin
    rd_peak  = '0;
    rd_sum   = '0;
    rd_count = '0;
    rd_ovf   = 1'b0;
    for (int i = 0; i < CHANNELS; i++) begin
      if (32'(s2_chan) == i && !s2_first) begin
        rd_peak  = peak_store[i];
        rd_sum   = sum_store[i];
        rd_count = count_store[i];
        rd_ovf   = ovf_store[i];
      end
    end
  end

  always_comb begin
    peak_next  = (s2_mag > rd_peak) ? s2_mag : rd_peak;
    sum_wide   = SUMX_W'(rd_sum) + SUMX_W'(s2_sq);
    sum_next   = rd_sum;
    count_next = rd_count;
    ovf_next   = rd_ovf;
    if (32'(rd_count) >= WINDOW_MAX) begin
      ovf_next = 1'b1;
    end else begin
      sum_next   = (sum_wide > SUMX_W'(SUM_LIMIT)) ? SUM_LIMIT : sum_wide[SUM_BITS-1:0];
      count_next = rd_count + 1'b1;
    end
  end

  assign push               = s2_valid && s2_last;
  assign push_data.chan     = s2_chan;
  assign push_data.peak     = LEVEL_BITS'(peak_next);
  assign push_data.sum      = sum_next;
  assign push_data.count    = REP_CNT_BITS'(count_next);
  assign push_data.overflow = ovf_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CHANNELS; i++) begin
        peak_store[i]  <= '0;
        sum_store[i]   <= '0;
        count_store[i] <= '0;
        ovf_store[i]   <= 1'b0;
      end
    end else if (s2_valid) begin
      for (int i = 0; i < CHANNELS; i++) begin
        if (32'(s2_chan) == i) begin
          // closing sample clears the channel after the report
          peak_store[i]  <= s2_last ? '0 : peak_next;
          sum_store[i]   <= s2_last ? '0 : sum_next;
          count_store[i] <= s2_last ? '0 : count_next;
          ovf_store[i]   <= s2_last ? 1'b0 : ovf_next;
        end
      end
    end
  end

endmodule

/* hdl/pawm_queue.sv */
`timescale 1ns / 1ps

module pawm_queue (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  pawm_pkg::pawm_rep_t   push_data,
  input  logic                  pop,
  output pawm_pkg::pawm_rep_t   head,
  output pawm_pkg::pawm_qstat_t qstat
);
  import pawm_pkg::*;

  localparam int PTR_W  = $clog2(QDEPTH);
  localparam int FILL_W = $clog2(QDEPTH + 1);

  pawm_rep_t         entries [QDEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [FILL_W-1:0] fill;

  assign head              = entries[rd_ptr];
  assign qstat.empty       = (fill == '0);
  // two samples may still be in the front pipeline
  assign qstat.almost_full = (32'(fill) >= QDEPTH - 2);

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

/* hdl/pawm_back.sv */
`timescale 1ns / 1ps

module pawm_back (
  input  logic                  clk,
  input  logic                  rst,
  input  pawm_pkg::pawm_rep_t   head,
  input  pawm_pkg::pawm_qstat_t qstat,
  output logic                  pop,
  output logic                  level_valid,
  input  logic                  level_stall,
  output pawm_pkg::pawm_out_t   level
);
  import pawm_pkg::*;

  typedef enum logic [2:0] {
    B_IDLE,
    B_DIV,
    B_PREP,
    B_ROOT,
    B_HOLD
  } bstate_t;

  localparam int STEP_W = $clog2(SUM_BITS);
  localparam int SREM_W = ROOT_BITS + 3;

  bstate_t                 state;
  logic [STEP_W-1:0]       step;

  logic [CHAN_BITS-1:0]    chan;
  logic [LEVEL_BITS-1:0]   peak;
  logic [REP_CNT_BITS-1:0] divisor;
  logic                    overflow;

  logic [SUM_BITS-1:0]     quo;
  logic [REP_CNT_BITS-1:0] rem;
  logic [RAD_BITS-1:0]     rad;
  logic [ROOT_BITS-1:0]    root;
  logic [SREM_W-1:0]       srem;

  logic [REP_CNT_BITS:0]   rem_sh;
  logic                    div_ge;
  logic [SREM_W-1:0]       srem_sh;
  logic [SREM_W-1:0]       trial;
  logic                    root_ge;

  assign pop = (state == B_IDLE) && !qstat.empty;

  // restoring divide step
  assign rem_sh = {rem, quo[SUM_BITS-1]};
  assign div_ge = (rem_sh >= {1'b0, divisor});

  // digit-by-digit root step
  assign srem_sh = {srem[SREM_W-3:0], rad[RAD_BITS-1 -: 2]};
  assign trial   = {1'b0, root, 2'b01};
  assign root_ge = (srem_sh >= trial);

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= B_IDLE;
      level_valid <= 1'b0;
    end else begin
      // the hold state reloads the output itself
      if (level_valid && !level_stall && state != B_HOLD) begin
        level_valid <= 1'b0;
      end
      case (state)
        B_IDLE: begin
          if (!qstat.empty) begin
            chan     <= head.chan;
            peak     <= head.peak;
            divisor  <= head.count;
            overflow <= head.overflow;
            quo      <= head.sum;
            rem      <= '0;
            step     <= '0;
            state    <= B_DIV;
          end
        end
        B_DIV: begin
          rem  <= div_ge ? REP_CNT_BITS'(rem_sh - {1'b0, divisor}) : rem_sh[REP_CNT_BITS-1:0];
          quo  <= {quo[SUM_BITS-2:0], div_ge};
          step <= step + 1'b1;
          if (step == STEP_W'(SUM_BITS - 1)) begin
            state <= B_PREP;
          end
        end
        B_PREP: begin
          rad   <= RAD_BITS'(quo);
          root  <= '0;
          srem  <= '0;
          step  <= '0;
          state <= B_ROOT;
        end
        B_ROOT: begin
          rad  <= {rad[RAD_BITS-3:0], 2'b00};
          srem <= root_ge ? (srem_sh - trial) : srem_sh;
          root <= {root[ROOT_BITS-2:0], root_ge};
          step <= step + 1'b1;
          if (step == STEP_W'(ROOT_BITS - 1)) begin
            state <= B_HOLD;
          end
        end
        B_HOLD: begin
          if (!level_valid || !level_stall) begin
            level_valid           <= 1'b1;
            level.out_chan        <= chan;
            level.peak_level      <= peak;
            level.rms_level       <= root[LEVEL_BITS-1:0];
            level.window_count    <= divisor[WCOUNT_BITS-1:0];
            level.window_overflow <= overflow;
            state                 <= B_IDLE;
          end
        end
        default: begin
          state <= B_IDLE;
        end
      endcase
    end
  end

endmodule

/* hdl/peak_and_rms_window_meter_top.sv */
`timescale 1ns / 1ps
// samples: one beat per cycle while sample_stall is low; a closing beat's report is pushed from stage 2
// reports: the back end takes one report at a time from the queue, then runs a 43-step
//   restoring divide, a setup state, a 22-step root and a load into the output register
// the four-entry report queue absorbs bursts of closing beats; sample_stall rises once two
//   reports are waiting, so the sustained report rate is set by the back end
// rst (synchronous, active high) clears all channel accumulators, the queue and level_valid

module peak_and_rms_window_meter_top #(
  parameter int CHANNELS    = pawm_pkg::CHANNELS_DEF,
  parameter int WINDOW_MAX  = pawm_pkg::WINDOW_MAX_DEF,
  parameter int SAMPLE_BITS = pawm_pkg::SAMPLE_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  // sample channel
  input  logic               sample_valid,
  output logic               sample_stall,
  input  pawm_pkg::pawm_in_t sample,
  // level report channel
  output logic               level_valid,
  input  logic               level_stall,
  output pawm_pkg::pawm_out_t level
);
  import pawm_pkg::*;

  // front to queue
  logic        push;
  pawm_rep_t   push_data;
  // queue to back
  logic        pop;
  pawm_rep_t   head;
  pawm_qstat_t qstat;

  // front: magnitude, square and per-channel accumulation, one beat per cycle unless stalled;
  // a closing beat pushes the finished window and clears the channel
  pawm_front #(
    .CHANNELS    (CHANNELS),
    .WINDOW_MAX  (WINDOW_MAX),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample       (sample),
    .qstat        (qstat),
    .push         (push),
    .push_data    (push_data)
  );

  // short queue of finished windows; the front stalls only once the queue is almost full
  pawm_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .qstat     (qstat)
  );

  // back: serial mean and root, then the output register
  pawm_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head        (head),
    .qstat       (qstat),
    .pop         (pop),
    .level_valid (level_valid),
    .level_stall (level_stall),
    .level       (level)
  );

endmodule
